### src/assert_macros.svh
// Assertion macros shared by the line min/max RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LIM_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: check failed");

// Same-cycle implication.
`define LIM_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication.
`define LIM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

### src/lim_pkg.sv
// Shared constants and types for the line integer min/max block.
package lim_pkg;

    localparam int LINE_LIMIT = 256;
    localparam int CNT_W      = $clog2(LINE_LIMIT);

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    localparam logic [31:0] MAG_CAP         = 32'h8000_0000;
    localparam logic [31:0] S32_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_START_RESET = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_START       = 32'hFFFF_FFFF;

    // What one byte does to the line's min/max tracking
    typedef struct packed {
        logic               line_start;
        logic               commit;
        logic signed [31:0] value;
        logic               eol;
        logic               truncated;
    } tok_evt_t;

endpackage

### src/lim_token.sv
// Token parser: sign/digit accumulation with saturation and line length count.
`include "assert_macros.svh"

module lim_token
    import lim_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] char_byte,
    output tok_evt_t   evt
);

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_SIGN   = 2'd1;
    localparam logic [1:0] PHASE_DIGITS = 2'd2;
    localparam logic [1:0] PHASE_SKIP   = 2'd3;

    logic [1:0]       phase_reg, phase_next, phase_step;
    logic             neg_reg, neg_next, neg_step;
    logic [31:0]      acc_reg, acc_next, acc_step, acc_sat;
    logic [CNT_W-1:0] line_count_reg, line_count_next, cnt_inc;
    logic [35:0]      acc_x10;
    logic [3:0]       digit;
    logic             is_digit, is_space, is_ws, is_sign, is_newline, eol;

    always_comb begin
        is_digit   = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
        is_space   = (char_byte == CHAR_SPACE);
        is_ws      = (char_byte >= CHAR_TAB) && (char_byte <= CHAR_CR);
        is_sign    = (char_byte == CHAR_PLUS) || (char_byte == CHAR_MINUS);
        is_newline = (char_byte == CHAR_NEWLINE);
        digit      = char_byte[3:0];

        acc_x10 = (36'(acc_reg) << 3) + (36'(acc_reg) << 1) + 36'(digit);
        acc_sat = (acc_x10 > 36'(MAG_CAP)) ? MAG_CAP : acc_x10[31:0];

        phase_step = phase_reg;
        neg_step   = neg_reg;
        acc_step   = acc_reg;
        if (is_space) begin
            phase_step = PHASE_IDLE;
        end else begin
            unique case (phase_reg)
                PHASE_IDLE: begin
                    priority if (is_ws) begin
                        phase_step = PHASE_IDLE;
                    end else if (is_sign) begin
                        neg_step   = (char_byte == CHAR_MINUS);
                        phase_step = PHASE_SIGN;
                    end else if (is_digit) begin
                        acc_step   = 32'(digit);
                        phase_step = PHASE_DIGITS;
                    end else begin
                        phase_step = PHASE_SKIP;
                    end
                end
                PHASE_SIGN: begin
                    if (is_digit) begin
                        acc_step   = 32'(digit);
                        phase_step = PHASE_DIGITS;
                    end else begin
                        phase_step = PHASE_SKIP;
                    end
                end
                PHASE_DIGITS: begin
                    if (is_digit) begin
                        acc_step = acc_sat;
                    end else begin
                        phase_step = PHASE_SKIP;
                    end
                end
                PHASE_SKIP: begin
                    phase_step = PHASE_SKIP;
                end
                default: begin
                    phase_step = PHASE_SKIP;
                end
            endcase
        end

        cnt_inc = line_count_reg + CNT_W'(1);
        eol     = is_newline || (cnt_inc >= CNT_W'(LINE_LIMIT - 1));

        // A number ends on a non-digit, or is cut off by the line end
        evt.line_start = (line_count_reg == '0);
        evt.commit     = ((phase_reg == PHASE_DIGITS) && !is_digit) ||
                         (eol && (phase_step == PHASE_DIGITS));
        if (neg_step) begin
            evt.value = -$signed(acc_step);
        end else begin
            evt.value = acc_step[31] ? $signed(S32_MAX) : $signed(acc_step);
        end
        evt.eol       = eol;
        evt.truncated = !is_newline;

        if (eol || is_space) begin
            phase_next = PHASE_IDLE;
            neg_next   = 1'b0;
            acc_next   = '0;
        end else begin
            phase_next = phase_step;
            neg_next   = neg_step;
            acc_next   = acc_step;
        end
        line_count_next = eol ? '0 : cnt_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PHASE_IDLE;
            neg_reg        <= 1'b0;
            acc_reg        <= '0;
            line_count_reg <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            acc_reg        <= acc_next;
            line_count_reg <= line_count_next;
        end
    end

    `LIM_ASSERT(a_count_below_limit, aclk, aresetn, line_count_reg < CNT_W'(LINE_LIMIT - 1))
    `LIM_ASSERT(a_acc_capped, aclk, aresetn, acc_reg <= MAG_CAP)
    `LIM_ASSERT_IMPL(a_idle_clean, aclk, aresetn, phase_reg == PHASE_IDLE, (acc_reg == '0) && !neg_reg)

endmodule

### src/lim_minmax.sv
// Running minimum and maximum of the values parsed on the current line.
module lim_minmax
    import lim_pkg::*;
(
    input  logic               aclk,
    input  logic               step,
    input  logic [31:0]        min_start,
    input  tok_evt_t           evt,
    output logic signed [31:0] line_min,
    output logic signed [31:0] line_max
);

    logic signed [31:0] run_min_reg, run_min_next;
    logic signed [31:0] run_max_reg, run_max_next;
    logic signed [31:0] base_min, base_max;

    always_comb begin
        base_min = evt.line_start ? $signed(min_start) : run_min_reg;
        base_max = evt.line_start ? $signed(MAX_START) : run_max_reg;
        line_min = (evt.commit && (evt.value < base_min)) ? evt.value : base_min;
        line_max = (evt.commit && (evt.value > base_max)) ? evt.value : base_max;
        run_min_next = evt.eol ? $signed(min_start) : line_min;
        run_max_next = evt.eol ? $signed(MAX_START) : line_max;
    end

    // Only read once a byte of the line has passed, so no reset needed
    always_ff @(posedge aclk) begin
        if (step) begin
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
    end

endmodule

### src/line_integer_min_max.sv
// Top level: per-line min/max of space-separated decimal integers in a byte stream.
//
// s_ channel: one text byte per item in s_tdata[7:0].
// m_ channel: one item per line, when a newline arrives or the line reaches
//   LINE_LIMIT-1 bytes. m_tdata holds line_min in [31:0] and line_max in [63:32];
//   m_tuser[0] is the truncated flag (line ended by length, not by newline).
// cfg_ channel: writes min_start, the starting minimum of each line. cfg_ready
//   is always high; write only while the block is idle.
// A byte accepted into the input register is parsed from there; a line result is
//   registered in the result register and is valid on m_ once its last byte is parsed.
// Throughput: one byte per cycle unless a line-ending byte waits on a stalled m_
//   side; set by the single parse stage between the input and result registers.
// A stalled m_ side holds its result; bytes that end no line keep flowing, and
//   the byte that ends the next line waits in the input register with s_tready
//   low until the result is taken.
// Reset (aresetn low, synchronous) empties both registers, clears the token and
//   line state and sets min_start to 2147483647.
`include "assert_macros.svh"

module line_integer_min_max
    import lim_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] line_min, [63:32] line_max
    output logic [0:0]  m_tuser,   // [0] truncated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               m_tvalid_reg;
    logic [31:0]        line_min_reg, line_max_reg;
    logic               truncated_reg;
    logic [31:0]        min_start_reg;
    logic               adv, s_fire;
    tok_evt_t           evt;
    logic signed [31:0] line_min, line_max;

    // Only a byte that ends a line needs room in the result register
    assign adv       = in_valid_reg && (!evt.eol || !m_tvalid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    lim_token u_token (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (adv),
        .char_byte (in_byte_reg),
        .evt       (evt)
    );

    lim_minmax u_minmax (
        .aclk      (aclk),
        .step      (adv),
        .min_start (min_start_reg),
        .evt       (evt),
        .line_min  (line_min),
        .line_max  (line_max)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            min_start_reg <= MIN_START_RESET;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv && evt.eol) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                min_start_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
        end
        if (adv && evt.eol) begin
            line_min_reg  <= line_min;
            line_max_reg  <= line_max;
            truncated_reg <= evt.truncated;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {line_max_reg, line_min_reg};
    assign m_tuser[0] = truncated_reg;

    `LIM_ASSERT_IMPL(a_rise_from_step, aclk, aresetn, $rose(m_tvalid_reg), $past(adv))
    `LIM_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_tready)
    `LIM_ASSERT_NEXT(a_stall_keeps_byte, aclk, aresetn, in_valid_reg && !adv, in_valid_reg)

endmodule

### test/line_integer_min_max_test.sv
// Self-checking testbench for line_integer_min_max: per-line min/max of parsed integers.
module line_integer_min_max_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lim_pkg::*;

    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_PAUSE    = 4;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_SIGN    = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_IGNORE  = 2'd3
    } tok_phase_e;

    typedef struct {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               trunc;
    } line_result_t;

    typedef logic [7:0] byte_q_t[$];

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    line_integer_min_max u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] char_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [31:0] line_min, [63:32] line_max
        .m_tuser   (m_tuser),    // [0] truncated
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow parser state
    logic signed [31:0] min_start = MIN_START_RESET;
    tok_phase_e         phase = PH_BETWEEN;
    logic               neg = 1'b0;
    logic [31:0]        mag = '0;
    logic signed [31:0] run_min = MIN_START_RESET;
    logic signed [31:0] run_max = -1;
    logic [15:0]        line_len = '0;

    line_result_t line_q[$];
    int           mismatches = 0;
    int           tx_max_gap = 0;
    int           rx_max_stall = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task automatic commit_token();
        logic signed [31:0] v;
        if (neg) begin
            v = (mag >= MAG_CAP) ? MAG_CAP : 32'(32'd0 - mag);
        end else begin
            v = (mag >= S32_MAX) ? S32_MAX : mag;
        end
        if (v < run_min) run_min = v;
        if (v > run_max) run_max = v;
    endtask

    task automatic clear_token();
        phase = PH_BETWEEN;
        neg   = 1'b0;
        mag   = '0;
    endtask

    task automatic predict_line(input logic [7:0] c);
        logic         is_dig;
        logic         is_ws;
        logic [7:0]   digit;
        logic [63:0]  wide;
        line_result_t r;
        is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_ws  = (c == CHAR_TAB) || (c == CHAR_NEWLINE) || (c == CHAR_VT) ||
                 (c == CHAR_FF) || (c == CHAR_CR);
        digit  = c - CHAR_ZERO;
        if (line_len == 0) begin
            run_min = min_start;
            run_max = -1;
        end
        if (c == CHAR_SPACE) begin
            if (phase == PH_DIGITS) commit_token();
            clear_token();
        end else begin
            case (phase)
                PH_BETWEEN: begin
                    if (is_ws) begin
                        // leading whitespace is skipped
                    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        neg   = (c == CHAR_MINUS);
                        phase = PH_SIGN;
                    end else if (is_dig) begin
                        mag   = {24'd0, digit};
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_IGNORE;
                    end
                end
                PH_SIGN: begin
                    if (is_dig) begin
                        mag   = {24'd0, digit};
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_IGNORE;
                    end
                end
                PH_DIGITS: begin
                    if (is_dig) begin
                        wide = {32'd0, mag} * 64'd10 + {56'd0, digit};
                        mag  = (wide > {32'd0, MAG_CAP}) ? MAG_CAP : wide[31:0];
                    end else begin
                        commit_token();
                        phase = PH_IGNORE;
                    end
                end
                default: ;
            endcase
        end
        line_len = line_len + 16'd1;
        if (c == CHAR_NEWLINE || line_len >= LINE_LIMIT - 1) begin
            if (phase == PH_DIGITS) commit_token();
            r.lo    = run_min;
            r.hi    = run_max;
            r.trunc = (c != CHAR_NEWLINE);
            line_q.push_back(r);
            clear_token();
            line_len = '0;
            run_min  = min_start;
            run_max  = -1;
        end
    endtask

    // Leaves s_tvalid high after acceptance; the next call or a drain decides.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predict_line(b);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic drain_lines();
        s_tvalid <= 1'b0;
        while (line_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic write_min_start(input logic signed [31:0] v);
        drain_lines();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_start = v;
        if (line_len == 0) run_min = v;
    endtask

    // One token: number with optional whitespace, sign, junk; or noise.
    task automatic add_token(ref byte_q_t q);
        longint unsigned m;
        string           s;
        int              kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0: q.push_back(CHAR_TAB);
                    1: q.push_back(CHAR_VT);
                    2: q.push_back(CHAR_FF);
                    default: q.push_back(CHAR_CR);
                endcase
            end
            case ($urandom_range(0, 3))
                0: q.push_back(CHAR_MINUS);
                1: q.push_back(CHAR_PLUS);
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0, 1: m = $urandom_range(0, 999);
                2:    m = $urandom;
                3:    m = 64'd2147483645 + $urandom_range(0, 5);
                4:    m = {$urandom, $urandom};
                default: m = $urandom_range(0, 99999);
            endcase
            if (kind == 1) q.push_back(CHAR_ZERO);
            if (kind != 2 || $urandom_range(0, 3) != 0) begin
                s = $sformatf("%0d", m);
                for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
            end
            if ($urandom_range(0, 5) == 0) q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_line(ref byte_q_t q);
        int ntok;
        ntok = $urandom_range(0, 6);
        for (int t = 0; t < ntok; t++) begin
            add_token(q);
            if (t < ntok - 1 || $urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 2)) q.push_back(CHAR_SPACE);
            end
        end
        q.push_back(CHAR_NEWLINE);
    endtask

    // Token text with no newline, exactly n bytes long.
    task automatic build_run(ref byte_q_t q, input int n);
        while (q.size() < n) begin
            add_token(q);
            q.push_back(CHAR_SPACE);
        end
        while (q.size() > n) void'(q.pop_back());
        foreach (q[i]) if (q[i] == CHAR_NEWLINE) q[i] = CHAR_SPACE;
    endtask

    function automatic logic signed [31:0] pick_min_start();
        case ($urandom_range(0, 4))
            0: return MAG_CAP;
            1: return S32_MAX;
            2: return 0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_malformed_tokens();
        // whitespace skip, signed value, sign then space, sign then junk, digits then junk
        send_str("\t+7 - +x 9z\n");
        // NUL and high bytes are plain junk; no value on this line
        send_byte(CHAR_VT);
        send_byte(8'h00);
        send_str("5 ");
        send_byte(CHAR_FF);
        send_byte(8'hFF);
        send_byte(CHAR_NEWLINE);
    endtask

    task automatic test_min_start_writes();
        send_str("-4 ");
        write_min_start(-100);       // line in progress keeps its minimum
        send_str("3\n");
        send_str("\n");
        write_min_start(MAG_CAP);
        send_str("7\n");
        write_min_start(0);
        send_str("5 -0\n");
        write_min_start(S32_MAX);
    endtask

    task automatic test_random_lines();
        byte_q_t q;
        int      sent;
        for (int chunk = 0; chunk < 6; chunk++) begin
            tx_max_gap   = (chunk == 1) ? 0 : $urandom_range(0, 8);
            rx_max_stall = (chunk == 1) ? 0 : $urandom_range(0, 8);
            sent = 0;
            while (sent < 160) begin
                q = {};
                build_line(q);
                send_bytes(q);
                sent += q.size();
            end
            if ($urandom_range(0, 2) == 0) send_str("6");
            write_min_start(pick_min_start());
        end
    endtask

    task automatic test_long_lines();
        byte_q_t q;
        tx_max_gap   = 2;
        rx_max_stall = 8;
        q = {};
        build_run(q, LINE_LIMIT - 1);        // cut by length
        send_bytes(q);
        q = {};
        build_run(q, LINE_LIMIT - 2);        // newline lands on the limit
        q.push_back(CHAR_NEWLINE);
        send_bytes(q);
        write_min_start(pick_min_start());
        q = {};
        build_run(q, 300);                   // cut, then the rest ends normally
        q.push_back(CHAR_NEWLINE);
        send_bytes(q);
        drain_lines();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_malformed_tokens();
        test_min_start_writes();
        test_random_lines();
        test_long_lines();
        drain_lines();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stall after each item
    int rx_stall = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else if (m_tready && m_tvalid) begin
            rx_stall = (rx_max_stall > 0) ? $urandom_range(0, rx_max_stall) : 0;
            m_tready <= (rx_stall == 0);
        end else if (!m_tready) begin
            if (rx_stall > 0) rx_stall--;
            if (rx_stall == 0) m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        line_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (line_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item min %0d max %0d trunc %0d",
                    $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tuser[0]));
            end else begin
                want = line_q.pop_front();
                if ($signed(m_tdata[31:0]) != want.lo)
                    report_mismatch($sformatf("line_min got %0d expected %0d",
                        $signed(m_tdata[31:0]), want.lo));
                if ($signed(m_tdata[63:32]) != want.hi)
                    report_mismatch($sformatf("line_max got %0d expected %0d",
                        $signed(m_tdata[63:32]), want.hi));
                if (m_tuser[0] != want.trunc)
                    report_mismatch($sformatf("truncated got %0d expected %0d",
                        m_tuser[0], want.trunc));
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
